// ----- rtl/core/nec_ir_frame_decoder_core_macros.svh -----
// Assertion macros shared by the NEC IR decoder RTL.
`ifndef NEC_IR_FRAME_DECODER_CORE_MACROS_SVH
`define NEC_IR_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NECIR_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("necir assertion failed");

// Next-cycle implication, checked outside reset.
`define NECIR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("necir assertion failed");

`endif

// ----- rtl/core/necir_pkg.sv -----
// Shared types and constants for the NEC IR frame decoder.
package necir_pkg;

  localparam int TimeWidth  = 16;
  localparam int CfgWidth   = 16;
  localparam int CodeWidth  = 32;
  localparam int FrameBits  = 32;
  localparam int CountWidth = 6;
  localparam int CfgAddrW   = 3;

  localparam logic [CfgWidth-1:0] StartMarkMinRst  = 16'd1600;
  localparam logic [CfgWidth-1:0] StartMarkMaxRst  = 16'd2900;
  localparam logic [CfgWidth-1:0] StartSpaceMinRst = 16'd800;
  localparam logic [CfgWidth-1:0] StartSpaceMaxRst = 16'd1500;
  localparam logic [CfgWidth-1:0] OneThresholdRst  = 16'd350;

  localparam logic [7:0] ByteMask = 8'hFF;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_FETCH = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_START_MARK_MIN  = 3'd0,
    REG_START_MARK_MAX  = 3'd1,
    REG_START_SPACE_MIN = 3'd2,
    REG_START_SPACE_MAX = 3'd3,
    REG_ONE_THRESHOLD   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                 ok;
    logic [CodeWidth-1:0] code;
  } frame_chk_t;

endpackage

// ----- rtl/core/necir_if.sv -----
// Valid/ready channel interfaces for edge/command items and results.
interface necir_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        edge_level;
  logic [15:0] edge_time;

  modport source (output valid, op, edge_level, edge_time, input ready);
  modport sink   (input valid, op, edge_level, edge_time, output ready);
endinterface

interface necir_out_if;
  logic        valid;
  logic        ready;
  logic        code_valid;
  logic [31:0] code_out;
  logic        code_pending;

  modport source (output valid, code_valid, code_out, code_pending, input ready);
  modport sink   (input valid, code_valid, code_out, code_pending, output ready);
endinterface

// ----- rtl/core/necir_frame_check.sv -----
// Inverse-byte check of a 32-bit NEC frame and byte reversal of the code.
module necir_frame_check (
  input  logic [necir_pkg::FrameBits-1:0] frame,
  output necir_pkg::frame_chk_t            chk
);
  import necir_pkg::*;

  logic [7:0] b0, b1, b2, b3;

  assign b0 = frame[7:0];
  assign b1 = frame[15:8];
  assign b2 = frame[23:16];
  assign b3 = frame[31:24];

  always_comb begin
    chk.ok   = ((~b0 & ByteMask) == b1) && ((~b2 & ByteMask) == b3);
    chk.code = {b0, b1, b2, b3};
  end

endmodule

// ----- rtl/core/nec_ir_frame_decoder_core.sv -----
// Top level of the NEC IR frame decoder: input stage, decode step, result stage.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless rsp.ready stalls the output; the decode step is
// one subtract, window compares and a bit insert between the input and result registers.
// Reset: synchronous on rst; clears both stages, decoder state and restores the
// default timing windows. No clearing pass is needed.
module nec_ir_frame_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  necir_in_if.sink                        req,
  necir_out_if.source                     rsp,
  input  logic                            cfg_we,
  input  logic [necir_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [necir_pkg::CfgWidth-1:0]  cfg_wdata
);
  import necir_pkg::*;

`include "nec_ir_frame_decoder_core_macros.svh"

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MARK = 2'd1,
    PH_RECV = 2'd2
  } phase_t;

  // configuration
  logic [CfgWidth-1:0] start_mark_min, start_mark_max;
  logic [CfgWidth-1:0] start_space_min, start_space_max;
  logic [CfgWidth-1:0] one_threshold;

  // input stage
  logic                 in_v;
  op_t                  in_op;
  logic                 in_level;
  logic [TimeWidth-1:0] in_time;

  // decoder state
  logic [TimeWidth-1:0]  last_edge_time, last_edge_time_next;
  phase_t                phase, phase_next;
  logic [FrameBits-1:0]  bit_shift, bit_shift_next;
  logic [CountWidth-1:0] bit_count, bit_count_next;
  logic [CodeWidth-1:0]  latched_code, latched_code_next;
  logic                  ready_flag, ready_flag_next;

  // result stage
  logic                 out_v;
  logic                 out_code_valid;
  logic [CodeWidth-1:0] out_code;
  logic                 out_pending;

  logic                  advance;
  logic                  step;
  logic [TimeWidth-1:0]  dt;
  logic [FrameBits-1:0]  shift_set;
  logic [CountWidth-1:0] count_inc;
  logic                  res_valid;
  logic [CodeWidth-1:0]  res_code;
  frame_chk_t            chk;

  assign advance   = !out_v || rsp.ready;
  assign step      = in_v && advance;
  assign req.ready = !in_v || advance;

  assign rsp.valid        = out_v;
  assign rsp.code_valid   = out_code_valid;
  assign rsp.code_out     = out_code;
  assign rsp.code_pending = out_pending;

  assign dt        = in_time - last_edge_time;
  assign count_inc = bit_count + CountWidth'(1);

  always_comb begin
    shift_set = bit_shift;
    if ((dt > TimeWidth'(one_threshold)) && (bit_count < CountWidth'(FrameBits))) begin
      shift_set[bit_count[CountWidth-2:0]] = 1'b1;
    end
  end

  necir_frame_check u_frame_check (
    .frame (shift_set),
    .chk   (chk)
  );

  always_comb begin
    last_edge_time_next = last_edge_time;
    phase_next          = phase;
    bit_shift_next      = bit_shift;
    bit_count_next      = bit_count;
    latched_code_next   = latched_code;
    ready_flag_next     = ready_flag;
    res_valid           = 1'b0;
    res_code            = '0;
    unique case (in_op)
      OP_EDGE: begin
        last_edge_time_next = in_time;
        if (in_level) begin
          if (phase != PH_MARK && phase != PH_RECV) begin
            if (dt >= TimeWidth'(start_mark_min) && dt <= TimeWidth'(start_mark_max)) begin
              phase_next = PH_MARK;
            end
          end
        end else if (phase == PH_MARK) begin
          if (dt >= TimeWidth'(start_space_min) && dt <= TimeWidth'(start_space_max)) begin
            phase_next     = PH_RECV;
            bit_count_next = '0;
            bit_shift_next = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (phase == PH_RECV) begin
          bit_shift_next = shift_set;
          bit_count_next = count_inc;
          // frame complete: latch on a good inverse check, always drop back to idle
          if (count_inc >= CountWidth'(FrameBits)) begin
            phase_next = PH_IDLE;
            if (chk.ok) begin
              latched_code_next = chk.code;
              ready_flag_next   = 1'b1;
            end
          end
        end
      end
      OP_FETCH: begin
        if (ready_flag) begin
          res_valid       = 1'b1;
          res_code        = latched_code;
          ready_flag_next = 1'b0;
        end
      end
      OP_FLUSH: begin
        ready_flag_next = 1'b0;
        phase_next      = PH_IDLE;
        bit_count_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark_min  <= StartMarkMinRst;
      start_mark_max  <= StartMarkMaxRst;
      start_space_min <= StartSpaceMinRst;
      start_space_max <= StartSpaceMaxRst;
      one_threshold   <= OneThresholdRst;
      in_v            <= 1'b0;
      out_v           <= 1'b0;
      last_edge_time  <= '0;
      phase           <= PH_IDLE;
      bit_shift       <= '0;
      bit_count       <= '0;
      latched_code    <= '0;
      ready_flag      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_START_MARK_MIN:  start_mark_min  <= cfg_wdata;
          REG_START_MARK_MAX:  start_mark_max  <= cfg_wdata;
          REG_START_SPACE_MIN: start_space_min <= cfg_wdata;
          REG_START_SPACE_MAX: start_space_max <= cfg_wdata;
          REG_ONE_THRESHOLD:   one_threshold   <= cfg_wdata;
          default: ;
        endcase
      end

      if (req.valid && req.ready) begin
        in_v     <= 1'b1;
        in_op    <= op_t'(req.op);
        in_level <= req.edge_level;
        in_time  <= req.edge_time;
      end else if (step) begin
        in_v <= 1'b0;
      end

      if (step) begin
        last_edge_time <= last_edge_time_next;
        phase          <= phase_next;
        bit_shift      <= bit_shift_next;
        bit_count      <= bit_count_next;
        latched_code   <= latched_code_next;
        ready_flag     <= ready_flag_next;
        out_v          <= 1'b1;
        out_code_valid <= res_valid;
        out_code       <= res_code;
        out_pending    <= ready_flag_next;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  `NECIR_ASSERT_NOW(a_recv_count, clk, rst, phase == PH_RECV, bit_count < CountWidth'(FrameBits))
  `NECIR_ASSERT_NOW(a_fetch_clears, clk, rst, out_v && out_code_valid, !out_pending)
  `NECIR_ASSERT_NOW(a_stall_held, clk, rst, !req.ready, in_v && out_v && !rsp.ready)
  `NECIR_ASSERT_NEXT(a_flush_idle, clk, rst, step && in_op == OP_FLUSH, phase == PH_IDLE && !ready_flag)

endmodule
